// ===== sv/iks_pkg.sv =====
`timescale 1ns / 1ps

package iks_pkg;

    // Fixed field widths of the stream payload.
    localparam int KEY_W   = 32;
    localparam int INDEX_W = 6;
    localparam int M_DATA_W = 40;

    // Run phases: LOAD takes keys into the chain, DRAIN streams them out.
    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } iks_state_t;

    // Control broadcast to every cell of the chain at once.
    typedef struct packed {
        logic insert;     // a new key is placed into the chain
        logic shift_out;  // cell 0 was taken, every entry moves one cell down
    } iks_ctrl_t;

endpackage

// ===== sv/integer_key_argsort.sv =====
`timescale 1ns / 1ps

// Channel  | Dir | tdata (low bit up)                      | tlast    | tuser
// ---------+-----+-----------------------------------------+----------+---------
// s_       | in  | [31:0] key                              | last_in  | -
// m_       | out | [31:0] sorted_key, [37:32] original_idx | last_out | overflow
//
// While loading, one key request is taken every cycle; each is inserted into
// a sorted chain of MAX_ITEMS cells in that same cycle, or dropped (overflow)
// if the chain is full. After the request marked last, the run drains from
// cell 0, one result per cycle while m_tready is high, and no input is taken
// until the final result has been accepted.
// Reset (aresetn low, synchronous) empties the chain and clears the counters.
// A stall on m_tready simply holds the chain; results are never lost.

module integer_key_argsort #(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_BITS  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [iks_pkg::KEY_W-1:0]     s_tdata,   // [31:0] key
    input  logic                          s_tlast,   // last_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [iks_pkg::M_DATA_W-1:0]  m_tdata,   // [31:0] sorted_key,
                                                     // [37:32] original_index,
                                                     // [39:38] zero
    output logic                          m_tlast,   // last_out
    output logic                          m_tuser    // overflow
);
    import iks_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    iks_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               dropped_reg, dropped_next;

    logic               s_accept;
    logic               m_accept;
    logic               full;
    iks_ctrl_t          ctrl;
    logic [KEY_BITS-1:0] new_key;
    logic [INDEX_W-1:0]  new_idx;

    // Chain taps; index MAX_ITEMS is the empty slot past the end.
    logic [MAX_ITEMS:0]                 c_valid;
    logic [MAX_ITEMS-1:0]               c_gt;
    logic [KEY_BITS-1:0]                c_key [MAX_ITEMS+1];
    logic [INDEX_W-1:0]                 c_idx [MAX_ITEMS+1];

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;
    assign full     = (count_reg == CNT_W'(MAX_ITEMS));

    // Only the low KEY_BITS bits of the key take part; a wider chain key is
    // zero-filled above bit 31.
    assign new_key = KEY_BITS'(s_tdata);
    assign new_idx = INDEX_W'(count_reg);

    assign ctrl.insert    = s_accept && !full;
    assign ctrl.shift_out = m_accept;

    assign c_valid[MAX_ITEMS] = 1'b0;
    assign c_key[MAX_ITEMS]   = '0;
    assign c_idx[MAX_ITEMS]   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            logic                prev_valid;
            logic                prev_gt;
            logic [KEY_BITS-1:0] prev_key;
            logic [INDEX_W-1:0]  prev_idx;

            if (gi == 0) begin : g_head
                // The head cell sees an always-present, never-greater neighbor.
                assign prev_valid = 1'b1;
                assign prev_gt    = 1'b0;
                assign prev_key   = '0;
                assign prev_idx   = '0;
            end else begin : g_body
                assign prev_valid = c_valid[gi-1];
                assign prev_gt    = c_gt[gi-1];
                assign prev_key   = c_key[gi-1];
                assign prev_idx   = c_idx[gi-1];
            end

            iks_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .new_key    (new_key),
                .new_idx    (new_idx),
                .prev_valid (prev_valid),
                .prev_gt    (prev_gt),
                .prev_key   (prev_key),
                .prev_idx   (prev_idx),
                .next_valid (c_valid[gi+1]),
                .next_key   (c_key[gi+1]),
                .next_idx   (c_idx[gi+1]),
                .valid      (c_valid[gi]),
                .gt         (c_gt[gi]),
                .key        (c_key[gi]),
                .idx        (c_idx[gi])
            );
        end
    endgenerate

    // Run control: count the stored keys, remember drops, and switch between
    // loading and draining.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_accept) begin
                    if (full) begin
                        dropped_next = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_tlast) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (m_accept && !c_valid[1]) begin
                    state_next   = ST_LOAD;
                    count_next   = '0;
                    dropped_next = 1'b0;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    // Results come straight from the head cell's registers.
    assign m_tvalid = (state_reg == ST_DRAIN) && c_valid[0];
    assign m_tdata  = {2'b00, c_idx[0], KEY_W'(signed'(c_key[0]))};
    assign m_tlast  = !c_valid[1];
    assign m_tuser  = dropped_reg;

    // The two channels never run in the same cycle.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output active together");

    // A drain always has a stored key at the head of the chain.
    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> c_valid[0])
        else $error("drain with empty chain");

    // The key count never passes the chain length.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("key count beyond capacity");

    // After the final result is taken the chain is empty and loading again.
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_accept && m_tlast) |=> (s_tready && !c_valid[0] && count_reg == '0
                                   && !dropped_reg))
        else $error("run state not cleared after final result");

endmodule

// ===== sv/iks_cell.sv =====
`timescale 1ns / 1ps

module iks_cell #(
    parameter int KEY_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  iks_pkg::iks_ctrl_t           ctrl,
    input  logic [KEY_BITS-1:0]          new_key,
    input  logic [iks_pkg::INDEX_W-1:0]  new_idx,
    input  logic                         prev_valid,
    input  logic                         prev_gt,
    input  logic [KEY_BITS-1:0]          prev_key,
    input  logic [iks_pkg::INDEX_W-1:0]  prev_idx,
    input  logic                         next_valid,
    input  logic [KEY_BITS-1:0]          next_key,
    input  logic [iks_pkg::INDEX_W-1:0]  next_idx,
    output logic                         valid,
    output logic                         gt,
    output logic [KEY_BITS-1:0]          key,
    output logic [iks_pkg::INDEX_W-1:0]  idx
);
    import iks_pkg::*;

    logic                valid_reg, valid_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [INDEX_W-1:0]  idx_reg, idx_next;
    logic                take_prev;
    logic                take_new;

    // Strictly greater keeps equal keys in arrival order.
    assign gt = valid_reg && ($signed(key_reg) > $signed(new_key));

    // The chain stays sorted, so the new key lands in the first cell that is
    // greater or empty, right after a cell that is not greater.
    assign take_prev = prev_gt;
    assign take_new  = !prev_gt && prev_valid && (gt || !valid_reg);

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        priority if (ctrl.shift_out) begin
            valid_next = next_valid;
            key_next   = next_key;
            idx_next   = next_idx;
        end else if (ctrl.insert && take_prev) begin
            valid_next = 1'b1;
            key_next   = prev_key;
            idx_next   = prev_idx;
        end else if (ctrl.insert && take_new) begin
            valid_next = 1'b1;
            key_next   = new_key;
            idx_next   = new_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        idx_reg <= idx_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign idx   = idx_reg;

endmodule

// ===== sim/iks_sort_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the argsort block, keeps its own sorted chain and
// compares every result request with the oldest expected entry.
module iks_sort_checker #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [iks_pkg::KEY_W-1:0]     s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [iks_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          m_tlast,
    input  logic                          m_tuser,
    output int                            fail_count,
    output int                            pending_results,
    output int                            results_seen,
    output int                            runs_seen,
    output int                            overflow_runs
);
    import iks_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               overflow;
    } sorted_entry_t;

    logic [KEY_W-1:0]   chain_key   [MAX_ITEMS];
    logic [INDEX_W-1:0] chain_index [MAX_ITEMS];
    int                 chain_len;
    bit                 run_dropped;
    sorted_entry_t      sorted_q [$];

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Stable insertion: a new key goes behind every stored key that is not
    // greater, so equal keys keep their arrival order.
    task automatic insert_key(input logic [KEY_W-1:0] key, input logic last);
        int            pos;
        sorted_entry_t entry;
        if (chain_len < MAX_ITEMS) begin
            pos = chain_len;
            while (pos > 0 && $signed(chain_key[pos-1]) > $signed(key)) begin
                chain_key[pos]   = chain_key[pos-1];
                chain_index[pos] = chain_index[pos-1];
                pos--;
            end
            chain_key[pos]   = key;
            chain_index[pos] = INDEX_W'(chain_len);
            chain_len++;
        end else begin
            run_dropped = 1'b1;
        end
        if (last) begin
            for (int i = 0; i < chain_len; i++) begin
                entry.key      = chain_key[i];
                entry.index    = chain_index[i];
                entry.last     = (i == chain_len - 1);
                entry.overflow = run_dropped;
                sorted_q.push_back(entry);
            end
            chain_len   = 0;
            run_dropped = 1'b0;
        end
    endtask

    task automatic check_result;
        sorted_entry_t want;
        if (sorted_q.size() == 0) begin
            report_mismatch($sformatf("result %h arrived with nothing expected", m_tdata));
            return;
        end
        want = sorted_q.pop_front();
        if (m_tdata[KEY_W-1:0] !== want.key)
            report_mismatch($sformatf("sorted_key %h, expected %h",
                                      m_tdata[KEY_W-1:0], want.key));
        if (m_tdata[KEY_W +: INDEX_W] !== want.index)
            report_mismatch($sformatf("original_index %0d, expected %0d",
                                      m_tdata[KEY_W +: INDEX_W], want.index));
        if (m_tdata[M_DATA_W-1:KEY_W+INDEX_W] !== '0)
            report_mismatch($sformatf("padding bits %b are not zero",
                                      m_tdata[M_DATA_W-1:KEY_W+INDEX_W]));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("last_out %b, expected %b", m_tlast, want.last));
        if (m_tuser !== want.overflow)
            report_mismatch($sformatf("overflow %b, expected %b", m_tuser, want.overflow));
        results_seen++;
        if (want.last) begin
            runs_seen++;
            if (want.overflow)
                overflow_runs++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            chain_len   = 0;
            run_dropped = 1'b0;
            sorted_q.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                insert_key(s_tdata, s_tlast);
        end
        pending_results = sorted_q.size();
    end

endmodule

// ===== sim/tb_integer_key_argsort.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the argsort block. The checker beside the block
// does all prediction and comparison; this module only builds runs of keys,
// throttles both channels and decides pass or fail at the end.
module tb_integer_key_argsort;
    import iks_pkg::*;

    localparam int MAX_ITEMS    = 64;
    localparam int RANDOM_ITEMS = 198;
    // Idling on both channels stops once this many keys have been sent.
    localparam int QUIET_AT     = 180;
    // Cycles allowed with no request moving on either channel.
    localparam int STALL_LIMIT  = 200;
    // Cycles watched after the final result, to catch stray results.
    localparam int TAIL_CYCLES  = 20;
    localparam int DIRECTED_N   = 22;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [KEY_W-1:0]      s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    int fail_count;
    int pending_results;
    int results_seen;
    int runs_seen;
    int overflow_runs;

    // Requests seen at the last rising edge, read back at the falling edge.
    logic s_fire = 1'b0;
    logic m_fire = 1'b0;
    int   stall_cycles = 0;
    int   items_sent = 0;
    bit   quiet = 1'b0;

    // Directed runs: a lone minimum key; the extremes with zero and +-1;
    // ties, including two equal minimum keys; a strictly falling run, so
    // each key lands at the head of the chain; a rising run; and two
    // alternating bit patterns.
    logic [KEY_W-1:0] dir_keys [DIRECTED_N] = '{
        32'h8000_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
        32'h0000_0007, 32'hFFFF_FFFE, 32'h0000_0007, 32'h0000_0007, 32'hFFFF_FFFE,
        32'h8000_0000, 32'h8000_0000,
        32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 32'h0000_0000,
        32'hFFFF_FFFD, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
        32'hAAAA_AAAA, 32'h5555_5555
    };
    bit dir_last [DIRECTED_N] = '{
        1,
        0, 0, 0, 0, 1,
        0, 0, 0, 0, 0, 0, 1,
        0, 0, 0, 1,
        0, 0, 1,
        0, 1
    };

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    integer_key_argsort #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_BITS  (KEY_W)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    iks_sort_checker #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_seen    (results_seen),
        .runs_seen       (runs_seen),
        .overflow_runs   (overflow_runs)
    );

    // Both handshakes are sampled here with the values from before the edge,
    // and the stimulus reads them back at the falling edge.
    always @(posedge aclk) begin
        s_fire <= s_tvalid && s_tready;
        m_fire <= m_tvalid && m_tready;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // A third each: full-range keys, the two extremes, and a narrow band around
    // zero, so that ties are common.
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return KEY_W'($urandom_range(0, 9)) - 32'd5;
            default: return $urandom;
        endcase
    endfunction

    // Presents one key request and returns at the falling edge after it was
    // taken. Valid stays high afterwards, so back-to-back keys need no gap.
    task automatic send_key(input logic [KEY_W-1:0] key, input logic last);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = key;
        s_tlast  = last;
        do @(negedge aclk); while (!s_fire);
        items_sent++;
        if (items_sent >= QUIET_AT)
            quiet = 1'b1;
    endtask

    // Holds the sender back until every expected result has been taken.
    task automatic wait_for_results;
        s_tvalid = 1'b0;
        while (pending_results != 0) @(negedge aclk);
    endtask

    // The result side: random stall bursts until the quiet part of the run.
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 14);
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int run_no;
        int run_len;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < DIRECTED_N; i++)
            send_key(dir_keys[i], dir_last[i]);
        wait_for_results();

        // Random runs, mostly short. The second run fills the store exactly;
        // the fourth overruns it, so its last request is itself dropped.
        run_no = 0;
        while (items_sent < DIRECTED_N + RANDOM_ITEMS) begin
            if (run_no == 1)
                run_len = MAX_ITEMS;
            else if (run_no == 3)
                run_len = MAX_ITEMS + 3;
            else if ($urandom_range(0, 9) == 0)
                run_len = $urandom_range(9, 40);
            else
                run_len = $urandom_range(1, 8);
            for (int i = 0; i < run_len; i++)
                send_key(pick_key(), i == run_len - 1);
            if ($urandom_range(0, 5) == 0)
                wait_for_results();
            run_no++;
        end

        s_tlast = 1'b0;
        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("sent %0d keys; checked %0d sorted results in %0d runs, %0d of them overrun",
                 items_sent, results_seen, runs_seen, overflow_runs);
        $display("runs covered lone keys, ties, extreme keys, a full store and a dropped tail");
        if (fail_count == 0 && pending_results == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
